FILE: rtl/core/pcgm_pkg.sv
// Package: constants, shared multiplier handshake types and the seed mix for the PCG32 generator.
`default_nettype none

package pcgm_pkg;

  localparam logic [63:0] LcgMul      = 64'h5851_f42d_4c95_7f2d;
  localparam logic [63:0] LcgInc      = 64'h1405_7b7e_f767_814f;
  localparam logic [63:0] GoldenGamma = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MixMulA     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MixMulB     = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned MixShiftA  = 30;
  localparam int unsigned MixShiftB  = 27;
  localparam int unsigned MixShiftC  = 31;
  localparam int unsigned XshShift   = 22;
  localparam int unsigned RotLsb     = 61;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } pcgm_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } pcgm_mul_rsp_t;

  function automatic logic [63:0] mix_seed(input logic [63:0] seed);
    logic [63:0] z;
    z = seed + GoldenGamma;
    z = (z ^ (z >> MixShiftA)) * MixMulA;
    z = (z ^ (z >> MixShiftB)) * MixMulB;
    return z ^ (z >> MixShiftC);
  endfunction

  localparam logic [63:0] ResetState = mix_seed(64'd0);

endpackage

`default_nettype wire

FILE: rtl/core/pcg32_generator_with_mix_seed.sv
// Top level: PCG XSH RS 64/32 generator with seed mixing, sequenced around one shared multiplier.
// Draw request: output valid once the multiply is done and the output is free; then a new request.
// Reseed request: no output; next request taken once two chained multiplies are done.
// The shared 32x32 multiplier makes four passes per 64-bit product; requests stall while it runs.
// A finished output waits in an output register; the next request is taken while it waits.
// Synchronous active-low reset loads the state with the mix of seed zero; no clearing pass.
`default_nettype none

module pcg32_generator_with_mix_seed (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [0:0]  in_kind,
  input  wire logic [63:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_random_fraction
);
  import pcgm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW,
    S_DRAW_OUT,
    S_MIX_A,
    S_MIX_B
  } state_t;

  state_t        state_r, state_nxt;
  logic [63:0]   gen_r, gen_nxt;
  logic [31:0]   word_r, word_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_frac_r, out_frac_nxt;
  pcgm_mul_req_t mul_req;
  pcgm_mul_rsp_t mul_rsp;
  logic [63:0]   seed_z;
  logic [63:0]   xsh;
  logic [5:0]    shamt;
  logic [63:0]   draw_shifted;
  logic          out_free;

  pcgm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign seed_z       = in_seed_value + GoldenGamma;
  assign xsh          = gen_r ^ (gen_r >> XshShift);
  assign shamt        = 6'(XshShift) + {3'b000, gen_r[63:RotLsb]};
  assign draw_shifted = xsh >> shamt;
  assign out_free     = !out_valid_r || !out_stall;

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_random_fraction = out_frac_r;

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_frac_nxt  = out_frac_r;
    mul_req.start = 1'b0;
    mul_req.a     = gen_r;
    mul_req.b     = LcgMul;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mul_req.start = 1'b1;
          if (in_kind[0]) begin
            mul_req.a = seed_z ^ (seed_z >> MixShiftA);
            mul_req.b = MixMulA;
            state_nxt = S_MIX_A;
          end else begin
            word_nxt  = draw_shifted[31:0];
            state_nxt = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        if (mul_rsp.done) begin
          gen_nxt = mul_rsp.product + LcgInc;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_frac_nxt  = word_r;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_DRAW_OUT;
          end
        end
      end
      S_DRAW_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_frac_nxt  = word_r;
          state_nxt     = S_IDLE;
        end
      end
      S_MIX_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.product ^ (mul_rsp.product >> MixShiftB);
          mul_req.b     = MixMulB;
          state_nxt     = S_MIX_B;
        end
      end
      S_MIX_B: begin
        if (mul_rsp.done) begin
          gen_nxt   = mul_rsp.product ^ (mul_rsp.product >> MixShiftC);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_r       <= ResetState;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r     <= word_nxt;
    out_frac_r <= out_frac_nxt;
  end

`ifndef SYNTHESIS
  a_done_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r != S_IDLE))
    else $error("multiply result with no request in flight");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted without starting work");
  a_wait_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW_OUT) |-> out_valid_r)
    else $error("output wait with empty output register");
  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW_OUT && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("held output not delivered");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pcgm_mul.sv
// Shared 64x64 mod 2^64 multiplier built from one 32x32 multiplier that forms the partial products in turn.
`default_nettype none

module pcgm_mul (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pcgm_pkg::pcgm_mul_req_t req,
  output pcgm_pkg::pcgm_mul_rsp_t      rsp
);
  import pcgm_pkg::*;

  logic        busy_r, busy_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] acc_sum;

  assign mul_a   = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign mul_b   = (step_r == 2'd1) ? b_r[63:32] : b_r[31:0];
  assign acc_sum = acc_r + {prod_r[31:0], 32'h0};

  assign rsp.done    = busy_r && (step_r == 2'd3);
  assign rsp.product = acc_sum;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (busy_r) begin
      step_nxt = step_r + 2'd1;
      prod_nxt = 64'(mul_a * mul_b);
      case (step_r)
        2'd1:    acc_nxt = prod_r;
        2'd2:    acc_nxt = acc_sum;
        2'd3:    busy_nxt = 1'b0;
        default: acc_nxt = acc_r;
      endcase
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      a_nxt    = req.a;
      b_nxt    = req.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

`ifndef SYNTHESIS
  a_no_start_midway: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r != 2'd3) |-> !req.start)
    else $error("multiply restarted before completion");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.done && !req.start) |=> !busy_r)
    else $error("multiplier busy after done");
  a_step_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> step_r == 2'd0)
    else $error("multiply started at wrong step");
`endif

endmodule

`default_nettype wire
